/* src/ita_pkg.sv */
package ita_pkg;

    // Mode codes
    localparam logic OP_SIGNED   = 1'b0;
    localparam logic OP_UNSIGNED = 1'b1;

    localparam logic [7:0]  ASCII_ZERO  = 8'h30;
    localparam logic [7:0]  ASCII_MINUS = 8'h2D;
    localparam logic [7:0]  DIGIT_MAX   = 8'd9;
    localparam logic [30:0] COUNT_MAX   = 31'h7FFF_FFFF;

    typedef struct packed {
        logic        op;
        logic [31:0] value;
        logic [30:0] prior_count;
    } item_t;

    typedef struct packed {
        logic [7:0]  character;
        logic        last;
        logic [30:0] total_count;
    } result_t;

    // Sequencer -> shift-and-add-3 unit
    typedef struct packed {
        logic load;
        logic digit_shift;
    } dab_ctrl_t;

    typedef struct packed {
        logic done;
    } dab_stat_t;

endpackage

/* src/ita_dabble.sv */
module ita_dabble
    import ita_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int DIGITS      = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dab_ctrl_t              ctrl,
    input  logic [VALUE_WIDTH-1:0] magnitude,
    output dab_stat_t              stat,
    output logic [3:0]             top_digit
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam int BCD_W = DIGITS * 4;

    logic [VALUE_WIDTH-1:0] bin_reg;
    logic [BCD_W-1:0]       bcd_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [BCD_W-1:0]       adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctrl.load)
        begin
            cnt_reg <= CNT_W'(VALUE_WIDTH);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            bin_reg <= magnitude;
            bcd_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            bcd_reg <= {adj[BCD_W-2:0], bin_reg[VALUE_WIDTH-1]};
            bin_reg <= {bin_reg[VALUE_WIDTH-2:0], 1'b0};
        end
        else if (ctrl.digit_shift)
        begin
            bcd_reg <= {bcd_reg[BCD_W-5:0], 4'd0};
        end
    end

    assign stat.done = (cnt_reg == '0);
    assign top_digit = bcd_reg[BCD_W-1 -: 4];

endmodule

/* src/int_to_decimal_ascii.sv */
// Decimal text of one word, most significant digit first, one character per result beat,
// with a leading '-' for a negative word in signed mode and the running count on every beat.
// An item is accepted, converted by serial shift-and-add-3 in the one conversion unit, then
// its leading zero digits are skipped (keeping at least one) and its sign and digit characters
// are sent, each one held back while the result side stalls. item_ready is high only while no
// item is in work.
module int_to_decimal_ascii
    import ita_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item_data,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result_data
);

    localparam int DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
    localparam int IDX_W  = $clog2(DIGITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_DIGIT
    } state_t;

    state_t                 state_reg;
    logic                   negative_flag_reg;
    logic [IDX_W-1:0]       digit_idx_reg;
    logic [30:0]            count_reg;
    logic [30:0]            count_next;
    logic                   result_valid_reg;
    result_t                result_reg;

    logic [VALUE_WIDTH+31:0] value_ext;
    logic [VALUE_WIDTH-1:0]  value_w;
    logic                    negative;
    logic [VALUE_WIDTH-1:0]  magnitude;
    logic                    slot_free;
    logic                    emit_beat;
    dab_ctrl_t               dab_ctrl;
    dab_stat_t               dab_stat;
    logic [3:0]              top_digit;

    assign value_ext = {{VALUE_WIDTH{1'b0}}, item_data.value};
    assign value_w   = value_ext[VALUE_WIDTH-1:0];
    assign negative  = (item_data.op == OP_SIGNED) && value_w[VALUE_WIDTH-1];
    assign magnitude = negative ? (~value_w + 1'b1) : value_w;

    assign item_ready = (state_reg == S_IDLE);
    assign slot_free  = !result_valid_reg || result_ready;
    assign emit_beat  = slot_free && ((state_reg == S_SIGN) || (state_reg == S_DIGIT));
    assign count_next = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 1'b1;

    always_comb
    begin
        dab_ctrl.load        = item_valid && item_ready;
        dab_ctrl.digit_shift = 1'b0;
        case (state_reg)
            S_SKIP:  dab_ctrl.digit_shift = (top_digit == 4'd0) && (digit_idx_reg != '0);
            S_DIGIT: dab_ctrl.digit_shift = slot_free;
            default: dab_ctrl.digit_shift = 1'b0;
        endcase
    end

    ita_dabble #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DIGITS      (DIGITS)
    ) u_dabble (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (dab_ctrl),
        .magnitude (magnitude),
        .stat      (dab_stat),
        .top_digit (top_digit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            negative_flag_reg <= 1'b0;
            digit_idx_reg     <= '0;
            count_reg         <= '0;
            result_valid_reg  <= 1'b0;
            result_reg        <= '0;
        end
        else
        begin
            if (result_valid_reg && result_ready && !emit_beat)
                result_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        negative_flag_reg <= negative;
                        count_reg         <= item_data.prior_count;
                        digit_idx_reg     <= IDX_W'(DIGITS - 1);
                        state_reg         <= S_CONV;
                    end
                end
                S_CONV:
                begin
                    if (dab_stat.done)
                        state_reg <= S_SKIP;
                end
                S_SKIP:
                begin
                    // drop leading zero digits, keeping at least one
                    if ((top_digit == 4'd0) && (digit_idx_reg != '0))
                        digit_idx_reg <= digit_idx_reg - 1'b1;
                    else if (negative_flag_reg)
                        state_reg <= S_SIGN;
                    else
                        state_reg <= S_DIGIT;
                end
                S_SIGN:
                begin
                    if (slot_free)
                    begin
                        result_reg.character   <= ASCII_MINUS;
                        result_reg.last        <= 1'b0;
                        result_reg.total_count <= count_next;
                        result_valid_reg       <= 1'b1;
                        count_reg              <= count_next;
                        state_reg              <= S_DIGIT;
                    end
                end
                S_DIGIT:
                begin
                    if (slot_free)
                    begin
                        result_reg.character   <= ASCII_ZERO + {4'd0, top_digit};
                        result_reg.last        <= (digit_idx_reg == '0);
                        result_reg.total_count <= count_next;
                        result_valid_reg       <= 1'b1;
                        count_reg              <= count_next;
                        if (digit_idx_reg == '0)
                            state_reg <= S_IDLE;
                        else
                            digit_idx_reg <= digit_idx_reg - 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

`ifndef ASSERT_OFF
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_data.character == ASCII_MINUS) |-> !result_data.last)
        else $error("minus sign flagged as last beat");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.character == ASCII_MINUS) ||
                         ((result_data.character >= ASCII_ZERO) &&
                          (result_data.character <= ASCII_ZERO + DIGIT_MAX)))
        else $error("result beat is neither a digit nor a minus sign");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready ##1 !item_ready)
        else $error("new item taken while conversion in progress");
`endif

endmodule
